### sv/next_fit_segment_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef NEXT_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH
`define NEXT_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define NFSA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define NFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/nfsa_pkg.sv
// Types, constants and codes of the next-fit segment allocator.
package nfsa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int OFF_W        = 16;
  localparam logic [OFF_W-1:0] POOL_RESET = 16'd1000;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_DOUBLE  = 3'd2;
  localparam logic [2:0] ST_BEYOND  = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic [1:0]       command;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] length;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] free_segments;
  } out_word_t;

  // One table entry: a free segment.
  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] len;
  } seg_t;

endpackage

### sv/nfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nfsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/next_fit_segment_allocator_core.sv
// Next-fit free-segment allocator: sequencer around one segment table RAM.
// An allocate searches the table and may then compact it; a free searches it and may then
// shift entries to merge or insert. Clear, zero-length and unused commands need no search.
// One word is in flight at a time; the one-read-per-cycle table RAM sets the pace. After
// reset the S_INIT state writes the whole-pool segment into entry 0 before the first word
// is accepted; configuration is taken at all times.
`include "next_fit_segment_allocator_core_defines.svh"

module next_fit_segment_allocator_core
  import nfsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [OFF_W-1:0] cfg_data
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_ASCAN = 10'b0000000100,
    S_FSCAN = 10'b0000001000,
    S_FEVAL = 10'b0000010000,
    S_SDN   = 10'b0000100000,
    S_SUP   = 10'b0001000000,
    S_FINS  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [OFF_W-1:0] pool_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] nfi_r, nfi_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] src_r, src_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic             drop_alloc_r, drop_alloc_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [OFF_W-1:0] len_r, len_nxt;
  seg_t             prev_r, prev_nxt;
  seg_t             next_r, next_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic             has_next_r, has_next_nxt;
  logic [2:0]       st_r, st_nxt;
  logic [OFF_W-1:0] where_r, where_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  seg_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  seg_t             ram_rdata;

  nfsa_ram #(
    .WIDTH($bits(seg_t)),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Current pointer once an entry has been removed. After an allocate it stays on the slot
  // that emptied; after a double merge it steps back if it lay at or beyond the removed entry.
  function automatic logic [IDX_W-1:0] drop_nfi(input logic             alloc,
                                                input logic [CNT_W-1:0] k,
                                                input logic [IDX_W-1:0] nfi,
                                                input logic [CNT_W-1:0] cnt_new);
    logic [CNT_W-1:0] n;
    if (alloc) begin
      n = k;
    end else begin
      n = {1'b0, nfi};
      if (n >= k) begin
        n = n - 1'b1;
      end
    end
    if (n >= cnt_new) begin
      n = '0;
    end
    return n[IDX_W-1:0];
  endfunction

  logic             accept;
  logic [OFF_W:0]   in_end;
  logic [OFF_W:0]   end_r;
  logic [OFF_W:0]   prev_end;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] src_ext;
  logic [OFF_W:0]   prev_merge;
  logic [OFF_W:0]   both_merge;
  logic [OFF_W:0]   next_merge;
  logic [OFF_W-1:0] alloc_left;
  logic             dbl;
  logic             mprev;
  logic             mnext;
  logic             nfi_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign in_end     = {1'b0, in_word.offset} + {1'b0, in_word.length};
  assign end_r      = {1'b0, off_r} + {1'b0, len_r};
  assign prev_end   = {1'b0, prev_r.start} + {1'b0, prev_r.len};
  assign idx_ext    = {1'b0, idx_r};
  assign src_ext    = {1'b0, src_r};
  assign prev_merge = {1'b0, prev_r.len} + {1'b0, len_r};
  assign both_merge = prev_merge + {1'b0, next_r.len};
  assign next_merge = {1'b0, next_r.len} + {1'b0, len_r};
  assign alloc_left = ram_rdata.len - len_r;

  // A range overlaps when it starts inside the segment before it or runs into the one after.
  assign dbl   = (have_prev_r && (prev_end > {1'b0, off_r})) ||
                 (has_next_r && (end_r > {1'b0, next_r.start}));
  assign mprev = have_prev_r && (prev_end == {1'b0, off_r});
  assign mnext = has_next_r && (end_r == {1'b0, next_r.start});

  assign nfi_ok = (state_r != S_IDLE) || (nfi_r == '0) || ({1'b0, nfi_r} < count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    nfi_nxt        = nfi_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    src_nxt        = src_r;
    p_nxt          = p_r;
    drop_alloc_nxt = drop_alloc_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    have_prev_nxt  = have_prev_r;
    has_next_nxt   = has_next_r;
    st_nxt         = st_r;
    where_nxt      = where_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    unique case (state_r)
      S_INIT: begin
        // Entry 0 becomes the whole pool straight after reset.
        ram_we          = 1'b1;
        ram_wdata.start = '0;
        ram_wdata.len   = pool_r;
        count_nxt       = (pool_r != '0) ? CNT_W'(1) : '0;
        nfi_nxt         = '0;
        state_nxt       = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          off_nxt   = in_word.offset;
          len_nxt   = in_word.length;
          st_nxt    = ST_OK;
          where_nxt = '0;
          state_nxt = S_FIN;
          case (in_word.command)
            CMD_ALLOC: begin
              if (in_word.length == '0) begin
                st_nxt = ST_ZERO;
              end else if (count_r == '0) begin
                st_nxt = ST_NOSPACE;
              end else begin
                cur_nxt   = ({1'b0, nfi_r} < count_r) ? nfi_r : '0;
                ram_raddr = cur_nxt;
                idx_nxt   = cur_nxt;
                n_nxt     = '0;
                state_nxt = S_ASCAN;
              end
            end
            CMD_FREE: begin
              if (in_word.length == '0) begin
                st_nxt = ST_ZERO;
              end else if (in_end > {1'b0, pool_r}) begin
                st_nxt = ST_BEYOND;
              end else if (count_r == '0) begin
                ram_we          = 1'b1;
                ram_wdata.start = in_word.offset;
                ram_wdata.len   = in_word.length;
                count_nxt       = CNT_W'(1);
                nfi_nxt         = '0;
              end else begin
                ram_raddr     = '0;
                idx_nxt       = '0;
                have_prev_nxt = 1'b0;
                has_next_nxt  = 1'b0;
                state_nxt     = S_FSCAN;
              end
            end
            CMD_CLEAR: begin
              ram_we          = 1'b1;
              ram_wdata.start = '0;
              ram_wdata.len   = pool_r;
              count_nxt       = (pool_r != '0) ? CNT_W'(1) : '0;
              nfi_nxt         = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ASCAN: begin
        // The read data belongs to entry idx_r; one entry is examined each cycle.
        if (ram_rdata.len >= len_r) begin
          where_nxt = ram_rdata.start;
          if (alloc_left != '0) begin
            ram_we          = 1'b1;
            ram_waddr       = idx_r;
            ram_wdata.start = ram_rdata.start + len_r;
            ram_wdata.len   = alloc_left;
            nfi_nxt         = idx_r;
            state_nxt       = S_FIN;
          end else begin
            drop_alloc_nxt = 1'b1;
            p_nxt          = idx_ext;
            if (idx_ext + 1'b1 < count_r) begin
              ram_raddr = idx_r + 1'b1;
              src_nxt   = idx_r + 1'b1;
              state_nxt = S_SDN;
            end else begin
              count_nxt = count_r - 1'b1;
              nfi_nxt   = drop_nfi(1'b1, idx_ext, nfi_r, count_r - 1'b1);
              state_nxt = S_FIN;
            end
          end
        end else if (n_r + 1'b1 == count_r) begin
          st_nxt    = ST_NOSPACE;
          nfi_nxt   = cur_r;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = (idx_ext + 1'b1 == count_r) ? '0 : idx_r + 1'b1;
          ram_raddr = idx_nxt;
          n_nxt     = n_r + 1'b1;
        end
      end

      S_FSCAN: begin
        // Walk in address order until the first segment that starts after the range's offset.
        if (ram_rdata.start <= off_r) begin
          prev_nxt      = ram_rdata;
          have_prev_nxt = 1'b1;
          if (idx_ext + 1'b1 == count_r) begin
            p_nxt     = count_r;
            state_nxt = S_FEVAL;
          end else begin
            ram_raddr = idx_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end else begin
          p_nxt        = idx_ext;
          next_nxt     = ram_rdata;
          has_next_nxt = 1'b1;
          state_nxt    = S_FEVAL;
        end
      end

      S_FEVAL: begin
        state_nxt = S_FIN;
        if (dbl) begin
          st_nxt = ST_DOUBLE;
        end else if (mprev && mnext) begin
          ram_we          = 1'b1;
          ram_waddr       = IDX_W'(p_r - 1'b1);
          ram_wdata.start = prev_r.start;
          ram_wdata.len   = both_merge[OFF_W-1:0];
          drop_alloc_nxt  = 1'b0;
          if (p_r + 1'b1 < count_r) begin
            ram_raddr = IDX_W'(p_r + 1'b1);
            src_nxt   = IDX_W'(p_r + 1'b1);
            state_nxt = S_SDN;
          end else begin
            count_nxt = count_r - 1'b1;
            nfi_nxt   = drop_nfi(1'b0, p_r, nfi_r, count_r - 1'b1);
          end
        end else if (mprev) begin
          ram_we          = 1'b1;
          ram_waddr       = IDX_W'(p_r - 1'b1);
          ram_wdata.start = prev_r.start;
          ram_wdata.len   = prev_merge[OFF_W-1:0];
          nfi_nxt         = ({1'b0, nfi_r} >= count_r) ? '0 : nfi_r;
        end else if (mnext) begin
          ram_we          = 1'b1;
          ram_waddr       = IDX_W'(p_r);
          ram_wdata.start = off_r;
          ram_wdata.len   = next_merge[OFF_W-1:0];
          nfi_nxt         = ({1'b0, nfi_r} >= count_r) ? '0 : nfi_r;
        end else if (count_r >= CNT_MAX) begin
          st_nxt = ST_FULL;
        end else if (p_r < count_r) begin
          // Open a gap at p by moving the tail up, last entry first.
          ram_raddr = IDX_W'(count_r - 1'b1);
          src_nxt   = IDX_W'(count_r - 1'b1);
          state_nxt = S_SUP;
        end else begin
          state_nxt = S_FINS;
        end
      end

      S_SDN: begin
        // Close the gap: entry src_r moves down by one.
        ram_we    = 1'b1;
        ram_waddr = src_r - 1'b1;
        ram_wdata = ram_rdata;
        if (src_ext + 1'b1 < count_r) begin
          ram_raddr = src_r + 1'b1;
          src_nxt   = src_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          nfi_nxt   = drop_nfi(drop_alloc_r, p_r, nfi_r, count_r - 1'b1);
          state_nxt = S_FIN;
        end
      end

      S_SUP: begin
        ram_we    = 1'b1;
        ram_waddr = src_r + 1'b1;
        ram_wdata = ram_rdata;
        if (src_ext > p_r) begin
          ram_raddr = src_r - 1'b1;
          src_nxt   = src_r - 1'b1;
        end else begin
          state_nxt = S_FINS;
        end
      end

      S_FINS: begin
        ram_we          = 1'b1;
        ram_waddr       = IDX_W'(p_r);
        ram_wdata.start = off_r;
        ram_wdata.len   = len_r;
        count_nxt       = count_r + 1'b1;
        if ({1'b0, nfi_r} >= p_r) begin
          nfi_nxt = nfi_r + 1'b1;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_r      <= POOL_RESET;
      count_r     <= '0;
      nfi_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      nfi_r   <= nfi_nxt;
      if (cfg_valid && cfg_ready) begin
        pool_r <= cfg_data;
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    src_r        <= src_nxt;
    p_r          <= p_nxt;
    drop_alloc_r <= drop_alloc_nxt;
    off_r        <= off_nxt;
    len_r        <= len_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    have_prev_r  <= have_prev_nxt;
    has_next_r   <= has_next_nxt;
    st_r         <= st_nxt;
    where_r      <= where_nxt;
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_word_r.status        <= st_r;
      out_word_r.block_offset  <= (st_r == ST_OK) ? where_r : '0;
      out_word_r.free_segments <= count_r;
    end
  end

  // The table never holds more entries than it has slots.
  `NFSA_ASSERT_ALWAYS(a_count_max, count_r <= CNT_MAX, "segment count beyond capacity")
  // Between words the current pointer names a held entry, or zero.
  `NFSA_ASSERT_ALWAYS(a_nfi_valid, nfi_ok, "current pointer outside the table")
  // An accepted word always leaves the idle state.
  `NFSA_ASSERT_NEXT(a_busy_after_accept, accept, state_r != S_IDLE, "accepted word did not start")

endmodule

### tb/tb.sv
// Self-checking testbench for the next-fit segment allocator core.
module tb;
  import nfsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 2 * MAX_SEGMENTS + 8;

  // Command code that the block must answer without touching the table.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_ready;
  out_word_t        out_word;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [OFF_W-1:0] cfg_data;

  // Shadow copy of the free-segment table.  Sums are kept in int so that
  // range ends above 16 bits are compared exactly.
  int        shadow_start [MAX_SEGMENTS];
  int        shadow_len   [MAX_SEGMENTS];
  int        shadow_count;
  int        shadow_cursor;
  int        shadow_pool;

  out_word_t pending_q [$];
  int        held_off  [$];
  int        held_len  [$];
  int        err_count;
  int        words_sent;
  int        words_seen;
  int        cycle_count = 0;

  next_fit_segment_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake must not stall the regression for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  function automatic void table_restore();
    shadow_start[0] = 0;
    shadow_len[0]   = shadow_pool;
    shadow_count    = (shadow_pool != 0) ? 1 : 0;
    shadow_cursor   = 0;
  endfunction

  function automatic void table_drop(int k);
    for (int i = k; i + 1 < shadow_count; i++) begin
      shadow_start[i] = shadow_start[i+1];
      shadow_len[i]   = shadow_len[i+1];
    end
    shadow_count--;
  endfunction

  // Next-fit search from the cursor, wrapping once round the table.
  function automatic logic [2:0] table_alloc(int len, output int where);
    int cur;
    int k;
    where = 0;
    if (len == 0) return ST_ZERO;
    if (shadow_count == 0) return ST_NOSPACE;
    cur = (shadow_cursor < shadow_count) ? shadow_cursor : 0;
    for (int n = 0; n < shadow_count; n++) begin
      k = cur + n;
      if (k >= shadow_count) k -= shadow_count;
      if (shadow_len[k] >= len) begin
        where           = shadow_start[k];
        shadow_start[k] = (shadow_start[k] + len) & 16'hFFFF;
        shadow_len[k]   = shadow_len[k] - len;
        if (shadow_len[k] == 0) begin
          table_drop(k);
          if (k >= shadow_count) k = 0;
        end
        shadow_cursor = k;
        return ST_OK;
      end
    end
    shadow_cursor = cur;
    return ST_NOSPACE;
  endfunction

  // Sorted insert with merging into whichever neighbours touch the range.
  function automatic logic [2:0] table_free(int off, int len);
    int  range_end;
    int  p;
    bit  join_prev;
    bit  join_next;
    range_end = off + len;
    if (len == 0) return ST_ZERO;
    if (range_end > shadow_pool) return ST_BEYOND;
    if (shadow_count == 0) begin
      shadow_start[0] = off;
      shadow_len[0]   = len;
      shadow_count    = 1;
      shadow_cursor   = 0;
      return ST_OK;
    end
    p = 0;
    while (p < shadow_count && shadow_start[p] <= off) p++;
    if (p > 0 && shadow_start[p-1] + shadow_len[p-1] > off) return ST_DOUBLE;
    if (p < shadow_count && range_end > shadow_start[p]) return ST_DOUBLE;
    join_prev = (p > 0) && (shadow_start[p-1] + shadow_len[p-1] == off);
    join_next = (p < shadow_count) && (range_end == shadow_start[p]);
    if (join_prev && join_next) begin
      shadow_len[p-1] = shadow_len[p-1] + len + shadow_len[p];
      table_drop(p);
      if (shadow_cursor >= p) shadow_cursor--;
    end else if (join_prev) begin
      shadow_len[p-1] = shadow_len[p-1] + len;
    end else if (join_next) begin
      shadow_start[p] = off;
      shadow_len[p]   = shadow_len[p] + len;
    end else begin
      if (shadow_count >= MAX_SEGMENTS) return ST_FULL;
      for (int i = shadow_count; i > p; i--) begin
        shadow_start[i] = shadow_start[i-1];
        shadow_len[i]   = shadow_len[i-1];
      end
      shadow_start[p] = off;
      shadow_len[p]   = len;
      shadow_count++;
      if (shadow_cursor >= p) shadow_cursor++;
    end
    if (shadow_cursor >= shadow_count) shadow_cursor = 0;
    return ST_OK;
  endfunction

  function automatic out_word_t table_step(in_word_t w);
    out_word_t r;
    int        where;
    where = 0;
    r.status = ST_OK;
    case (w.command)
      CMD_ALLOC: r.status = table_alloc(int'(w.length), where);
      CMD_FREE:  r.status = table_free(int'(w.offset), int'(w.length));
      CMD_CLEAR: table_restore();
      default:   ;
    endcase
    r.block_offset  = (r.status == ST_OK) ? where[OFF_W-1:0] : '0;
    r.free_segments = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Sends one word after a random gap and records what the block must answer.
  // Valid is only lowered when a gap follows, so a back-to-back word never sees
  // two assignments to in_valid in one time step.
  task automatic send_word(input logic [1:0] cmd, input int off, input int len,
                           output out_word_t res);
    in_word_t w;
    int       gap;
    w.command = cmd;
    w.offset  = off[OFF_W-1:0];
    w.length  = len[OFF_W-1:0];
    gap = $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = table_step(w);
    pending_q.push_back(res);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the pool size; only done once the block has gone quiet.
  task automatic write_pool(input int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value[OFF_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    shadow_pool  = value & 16'hFFFF;
  endtask

  task automatic do_alloc(input int len);
    out_word_t r;
    send_word(CMD_ALLOC, $urandom_range(0, 65535), len, r);
    if (r.status == ST_OK) begin
      held_off.push_back(int'(r.block_offset));
      held_len.push_back(len);
    end
  endtask

  task automatic do_free(input int off, input int len);
    out_word_t r;
    send_word(CMD_FREE, off, len, r);
  endtask

  task automatic do_clear();
    out_word_t r;
    send_word(CMD_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535), r);
    held_off.delete();
    held_len.delete();
  endtask

  // Returns one block that the allocator handed out, whole or only its front.
  task automatic free_held();
    int k;
    int part;
    k = $urandom_range(0, held_off.size() - 1);
    if (held_len[k] > 1 && $urandom_range(0, 3) == 0) begin
      part = $urandom_range(1, held_len[k] - 1);
      do_free(held_off[k], part);
      held_off[k] += part;
      held_len[k] -= part;
    end else begin
      do_free(held_off[k], held_len[k]);
      held_off.delete(k);
      held_len.delete(k);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker with random back-pressure
  // ---------------------------------------------------------------------------

  initial begin
    int        stall;
    out_word_t want;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words_seen++;
      if (pending_q.size() == 0) begin
        $error("result word with no request outstanding: %p", out_word);
        err_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          err_count++;
        end
        if (out_word.block_offset !== want.block_offset) begin
          $error("block_offset: expected %0d, got %0d",
                 want.block_offset, out_word.block_offset);
          err_count++;
        end
        if (out_word.free_segments !== want.free_segments) begin
          $error("free_segments: expected %0d, got %0d",
                 want.free_segments, out_word.free_segments);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Error codes, a plain three-block split and rejoin, the unused command and an
  // emptied table.
  task automatic test_directed();
    out_word_t r;
    do_alloc(0);
    do_free(10, 0);
    do_alloc(65535);
    do_alloc(100);
    do_free(950, 100);
    do_free(500, 10);
    do_free(99, 2);
    do_free(0, 100);
    do_alloc(10);
    do_alloc(10);
    do_alloc(10);
    do_free(10, 10);
    do_free(0, 10);
    do_free(20, 10);
    send_word(CMD_UNUSED, 65535, 65535, r);
    do_clear();
    do_alloc(1000);
    do_alloc(1);
    do_free(5, 5);
    do_alloc(5);
    do_clear();
  endtask

  // Fragments the pool until the table overflows, then stitches it together.
  task automatic test_table_full();
    do_clear();
    for (int i = 0; i < 2 * MAX_SEGMENTS + 2; i++) do_alloc(1);
    for (int i = 0; i < 2 * MAX_SEGMENTS + 2; i += 2) do_free(i, 1);
    for (int i = 1; i < 2 * MAX_SEGMENTS + 2; i += 2) do_free(i, 1);
    held_off.delete();
    held_len.delete();
    wait_idle();
  endtask

  // Mostly allocations and returns of held blocks, with noise and clears mixed in.
  task automatic test_random(input int words, input int max_len);
    int pick;
    for (int n = 0; n < words; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 9) == 0) do_alloc($urandom_range(0, 65535));
        else do_alloc($urandom_range(1, max_len));
      end else if (pick < 82 && held_off.size() != 0) begin
        free_held();
      end else if (pick < 94) begin
        if ($urandom_range(0, 1) == 0) do_free($urandom_range(0, 65535),
                                               $urandom_range(0, 65535));
        else do_free($urandom_range(0, shadow_pool), $urandom_range(0, max_len));
      end else if (pick < 97) begin
        do_clear();
      end else begin
        do_alloc(0);
      end
    end
  endtask

  // Pool size changes: extremes, zero pool and a change that waits for a clear.
  task automatic test_pool_sizes();
    write_pool(65535);
    do_free(65000, 600);
    do_clear();
    do_alloc(65535);
    do_free(0, 65535);
    test_random(300, 4096);
    write_pool(1);
    do_clear();
    do_alloc(2);
    do_alloc(1);
    do_free(0, 1);
    do_free(0, 2);
    test_random(40, 2);
    write_pool(0);
    do_clear();
    do_alloc(1);
    do_free(0, 1);
    write_pool($urandom_range(2, 65534));
    test_random(200, 300);
    do_clear();
    test_random(200, 300);
    write_pool(1000);
    do_clear();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    err_count   = 0;
    words_sent  = 0;
    words_seen  = 0;
    shadow_pool = int'(POOL_RESET);
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      shadow_start[i] = 0;
      shadow_len[i]   = 0;
    end
    table_restore();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(300, 64);
    test_table_full();
    test_pool_sizes();
    test_random(100, 64);

    wait_idle();
    $display("Sent %0d request words and checked %0d result words against the model.",
             words_sent, words_seen);
    $display("Covered next-fit allocation, merging frees, every error code and pool sizes.");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
